FILE: design/lab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lab_pkg
// Constants shared by the look-at basis unit and its submodules.
// ----------------------------------------------------------------------------
package lab_pkg;

    localparam int IN_W     = 32;  // Q16.16 input component
    localparam int OUT_W    = 16;  // Q2.14 output component
    localparam int FRAC_W   = 14;  // fraction bits of an output component
    localparam int UNIT_ONE = 16384;
    localparam int NORM_BIT = 29;  // largest magnitude lands in [2^29, 2^30)
    localparam int MAG_W    = NORM_BIT + 1;
    localparam int SQ_W     = 2 * MAG_W + 2;      // sum of three squares
    localparam int ROOT_W   = SQ_W / 2;           // bits of the square root
    localparam int QUO_W    = FRAC_W + 1;         // quotient bits
    localparam int NUM_W    = MAG_W + FRAC_W + 1; // dividend bits

endpackage

FILE: design/lab_cross.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lab_cross
// Two-stage pipelined cross product: products, then differences.
// ----------------------------------------------------------------------------
module lab_cross #(
    parameter int AW   = 32,
    parameter int BW   = 16,
    parameter int SB_W = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [2:0][AW-1:0]       i_a,
    input  logic [2:0][BW-1:0]       i_b,
    input  logic [SB_W-1:0]          i_sb,
    output logic                     o_valid,
    output logic [2:0][AW+BW:0]      o_vec,
    output logic [SB_W-1:0]          o_sb
);
    import lab_pkg::*;

    localparam int PW = AW + BW;

    logic signed [PW-1:0] n_p [6];
    logic signed [PW-1:0] r_p [6];
    logic                 r_pv;
    logic [SB_W-1:0]      r_psb;
    logic [2:0][PW:0]     r_vec;
    logic                 r_ov;
    logic [SB_W-1:0]      r_osb;

    // Products are ordered in pairs whose difference gives one component.
    always_comb begin
        n_p[0] = $signed(i_a[1]) * $signed(i_b[2]);
        n_p[1] = $signed(i_a[2]) * $signed(i_b[1]);
        n_p[2] = $signed(i_a[2]) * $signed(i_b[0]);
        n_p[3] = $signed(i_a[0]) * $signed(i_b[2]);
        n_p[4] = $signed(i_a[0]) * $signed(i_b[1]);
        n_p[5] = $signed(i_a[1]) * $signed(i_b[0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_pv <= i_valid;
            r_ov <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 6; k++) begin
                r_p[k] <= n_p[k];
            end
            r_psb <= i_sb;
            for (int k = 0; k < 3; k++) begin
                r_vec[k] <= {r_p[2*k][PW-1], r_p[2*k]} - {r_p[2*k+1][PW-1], r_p[2*k+1]};
            end
            r_osb <= r_psb;
        end
    end

    assign o_valid = r_ov;
    assign o_vec   = r_vec;
    assign o_sb    = r_osb;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_ov) && $stable(r_pv))
        else $error("cross pipeline valid moved during a stall");
    a_hold_prod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en && r_pv |=> r_pv && $stable(r_p[0]) && $stable(r_p[5]))
        else $error("cross products changed during a stall");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en && r_ov |=> $stable(r_vec))
        else $error("cross result changed during a stall");

endmodule

FILE: design/lab_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lab_norm
// Pipelined vector normalization to Q2.14: magnitude, leading-one search,
// alignment shift, squares, one-bit-per-stage square root and one-bit-per-
// stage restoring division with rounding.
// ----------------------------------------------------------------------------
module lab_norm #(
    parameter int W    = 33,
    parameter int SB_W = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [2:0][W-1:0]               i_vec,
    input  logic [SB_W-1:0]                 i_sb,
    output logic                            o_valid,
    output logic [2:0][lab_pkg::OUT_W-1:0]  o_vec,
    output logic                            o_zero,
    output logic [SB_W-1:0]                 o_sb
);
    import lab_pkg::*;

    localparam int PW   = $clog2(W);
    localparam int WIDE = W + NORM_BIT;

    typedef struct packed {
        logic [2:0]      neg;
        logic            zero;
        logic [SB_W-1:0] sb;
    } t_meta;

    // Stage 1: magnitudes.
    logic [2:0][W-1:0] n1_mag;
    logic [2:0][W-1:0] r1_mag;
    t_meta             r1_m;
    logic              r1_v;

    // Stage 2: leading one of the largest magnitude.
    logic [W-1:0]      s2_or;
    logic [PW-1:0]     n2_p;
    logic [2:0][W-1:0] r2_mag;
    logic [PW-1:0]     r2_p;
    t_meta             r2_m;
    logic              r2_v;

    // Stage 3: alignment.
    logic [WIDE-1:0]       s3_w [3];
    logic [2:0][MAG_W-1:0] r3_mag;
    t_meta                 r3_m;
    logic                  r3_v;

    // Stage 4: squares.
    logic [2:0][2*MAG_W-1:0] r4_sq;
    logic [2:0][MAG_W-1:0]   r4_mag;
    t_meta                   r4_m;
    logic                    r4_v;

    // Square root stages; index 0 holds the sum of squares.
    logic [SQ_W-1:0]       r_sx   [0:ROOT_W];
    logic [SQ_W:0]         r_sr   [0:ROOT_W];
    logic [2:0][MAG_W-1:0] r_smag [0:ROOT_W];
    t_meta                 r_sm   [0:ROOT_W];
    logic                  r_sv   [0:ROOT_W];

    // Division stages; index 0 holds the rounded dividends.
    logic [2:0][NUM_W-1:0] r_dr [0:QUO_W];
    logic [2:0][QUO_W-1:0] r_dq [0:QUO_W];
    logic [ROOT_W-1:0]     r_dl [0:QUO_W];
    t_meta                 r_dm [0:QUO_W];
    logic                  r_dv [0:QUO_W];

    logic [ROOT_W-1:0]     s_len;
    logic [2:0][OUT_W-1:0] n_out;
    logic [2:0][OUT_W-1:0] r_out;
    t_meta                 r_om;
    logic                  r_ov;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n1_mag[k] = i_vec[k][W-1] ? (~i_vec[k] + 1'b1) : i_vec[k];
        end
    end

    // The leading one of the largest magnitude is the leading one of the OR.
    always_comb begin
        s2_or = r1_mag[0] | r1_mag[1] | r1_mag[2];
        n2_p  = '0;
        for (int b = 0; b < W; b++) begin
            if (s2_or[b]) begin
                n2_p = PW'(b);
            end
        end
    end

    // Shift so that the largest magnitude has its top bit at NORM_BIT.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s3_w[k] = {r2_mag[k], {NORM_BIT{1'b0}}} >> r2_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r_sv[0] <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r_sv[0] <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag <= n1_mag;
            r1_m.neg <= {i_vec[2][W-1], i_vec[1][W-1], i_vec[0][W-1]};
            r1_m.zero <= 1'b0;
            r1_m.sb <= i_sb;

            r2_mag <= r1_mag;
            r2_p <= n2_p;
            r2_m.neg <= r1_m.neg;
            r2_m.zero <= (s2_or == '0);
            r2_m.sb <= r1_m.sb;

            for (int k = 0; k < 3; k++) begin
                r3_mag[k] <= s3_w[k][MAG_W-1:0];
            end
            r3_m <= r2_m;

            for (int k = 0; k < 3; k++) begin
                r4_sq[k] <= r3_mag[k] * r3_mag[k];
            end
            r4_mag <= r3_mag;
            r4_m <= r3_m;

            r_sx[0] <= SQ_W'(r4_sq[0]) + SQ_W'(r4_sq[1]) + SQ_W'(r4_sq[2]);
            r_sr[0] <= '0;
            r_smag[0] <= r4_mag;
            r_sm[0] <= r4_m;
        end
    end

    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        localparam logic [SQ_W:0] BIT = (SQ_W+1)'(1) << (2 * (ROOT_W - 1 - j));
        logic [SQ_W:0]   s_t;
        logic            s_ge;
        logic [SQ_W-1:0] n_x;
        logic [SQ_W:0]   n_r;

        always_comb begin
            s_t  = r_sr[j] + BIT;
            s_ge = ({1'b0, r_sx[j]} >= s_t);
            n_x  = s_ge ? (r_sx[j] - s_t[SQ_W-1:0]) : r_sx[j];
            n_r  = s_ge ? ((r_sr[j] >> 1) + BIT) : (r_sr[j] >> 1);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[j+1] <= 1'b0;
            end else if (i_en) begin
                r_sv[j+1] <= r_sv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sx[j+1]   <= n_x;
                r_sr[j+1]   <= n_r;
                r_smag[j+1] <= r_smag[j];
                r_sm[j+1]   <= r_sm[j];
            end
        end
    end

    assign s_len = r_sr[ROOT_W][ROOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (i_en) begin
            r_dv[0] <= r_sv[ROOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_dr[0][k] <= NUM_W'({r_smag[ROOT_W][k], {FRAC_W{1'b0}}})
                            + NUM_W'(s_len >> 1);
            end
            r_dq[0] <= '0;
            r_dl[0] <= s_len;
            r_dm[0] <= r_sm[ROOT_W];
        end
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        localparam int SH = QUO_W - 1 - j;
        logic [NUM_W:0]        s_d;
        logic [2:0]            s_ge;
        logic [2:0][NUM_W-1:0] n_rem;
        logic [2:0][QUO_W-1:0] n_q;

        always_comb begin
            s_d = (NUM_W+1)'(r_dl[j]) << SH;
            for (int k = 0; k < 3; k++) begin
                s_ge[k]  = ({1'b0, r_dr[j][k]} >= s_d);
                n_rem[k] = s_ge[k] ? (r_dr[j][k] - s_d[NUM_W-1:0]) : r_dr[j][k];
                n_q[k]   = {r_dq[j][k][QUO_W-2:0], s_ge[k]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j+1] <= 1'b0;
            end else if (i_en) begin
                r_dv[j+1] <= r_dv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dr[j+1] <= n_rem;
                r_dq[j+1] <= n_q;
                r_dl[j+1] <= r_dl[j];
                r_dm[j+1] <= r_dm[j];
            end
        end
    end

    // Clamp to one, restore the sign and force zero for a null vector.
    always_comb begin
        logic [QUO_W-1:0] c;
        logic [OUT_W-1:0] u;
        for (int k = 0; k < 3; k++) begin
            c = (r_dq[QUO_W][k] > QUO_W'(UNIT_ONE)) ? QUO_W'(UNIT_ONE) : r_dq[QUO_W][k];
            u = {1'b0, c};
            if (r_dm[QUO_W].zero) begin
                n_out[k] = '0;
            end else if (r_dm[QUO_W].neg[k]) begin
                n_out[k] = ~u + 1'b1;
            end else begin
                n_out[k] = u;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_dv[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
            r_om  <= r_dm[QUO_W];
        end
    end

    assign o_valid = r_ov;
    assign o_vec   = r_out;
    assign o_zero  = r_om.zero;
    assign o_sb    = r_om.sb;

    a_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_v && !r3_m.zero |-> ((r3_mag[0] | r3_mag[1] | r3_mag[2]) >> NORM_BIT) == 1)
        else $error("aligned magnitude outside the normal range");
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv[ROOT_W] && !r_sm[ROOT_W].zero |-> s_len[ROOT_W-1:NORM_BIT] != '0)
        else $error("square root below the aligned magnitude");
    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv[QUO_W] && !r_dm[QUO_W].zero |->
            r_dq[QUO_W][0] <= QUO_W'(UNIT_ONE) && r_dq[QUO_W][1] <= QUO_W'(UNIT_ONE)
            && r_dq[QUO_W][2] <= QUO_W'(UNIT_ONE))
        else $error("normalized component above one");

endmodule

FILE: design/look_at_basis_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_basis_unit
// Orthonormal camera basis (side, up, forward) from eye, target and up.
// ----------------------------------------------------------------------------
// The unit takes one beat of eye, target and approximate up vectors (Q16.16)
// per cycle and returns one beat with the three unit axes in Q2.14: forward
// is the normalized eye minus target, side is up cross forward normalized,
// and the new up is forward cross side normalized. If any of these vectors
// is null the degenerate flag is set and all nine components are zero. The
// unit is a fully pipelined chain of three normalizers with a two-stage
// cross product between them, so it sustains one beat per clock while the
// output beat is not held. Each normalizer has an exact square root (31
// stages, one root bit each) and a rounded division (15 stages, one quotient
// bit each). When the output beat is held by o_stall's counterpart i_stall,
// the whole pipeline holds and o_stall rises; nothing is dropped or repeated.
module look_at_basis_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [lab_pkg::IN_W-1:0]      i_eye_x,
    input  logic signed [lab_pkg::IN_W-1:0]      i_eye_y,
    input  logic signed [lab_pkg::IN_W-1:0]      i_eye_z,
    input  logic signed [lab_pkg::IN_W-1:0]      i_target_x,
    input  logic signed [lab_pkg::IN_W-1:0]      i_target_y,
    input  logic signed [lab_pkg::IN_W-1:0]      i_target_z,
    input  logic signed [lab_pkg::IN_W-1:0]      i_up_in_x,
    input  logic signed [lab_pkg::IN_W-1:0]      i_up_in_y,
    input  logic signed [lab_pkg::IN_W-1:0]      i_up_in_z,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [lab_pkg::OUT_W-1:0]     o_side_x,
    output logic signed [lab_pkg::OUT_W-1:0]     o_side_y,
    output logic signed [lab_pkg::OUT_W-1:0]     o_side_z,
    output logic signed [lab_pkg::OUT_W-1:0]     o_up_out_x,
    output logic signed [lab_pkg::OUT_W-1:0]     o_up_out_y,
    output logic signed [lab_pkg::OUT_W-1:0]     o_up_out_z,
    output logic signed [lab_pkg::OUT_W-1:0]     o_fwd_x,
    output logic signed [lab_pkg::OUT_W-1:0]     o_fwd_y,
    output logic signed [lab_pkg::OUT_W-1:0]     o_fwd_z,
    output logic                                 o_degenerate
);
    import lab_pkg::*;

    localparam int D_W  = IN_W + 1;           // eye minus target
    localparam int C1_W = IN_W + OUT_W + 1;   // up cross forward
    localparam int C2_W = 2 * OUT_W + 1;      // forward cross side

    typedef struct packed {
        logic                  zero;
        logic [2:0][OUT_W-1:0] fwd;
    } t_fwd_sb;

    typedef struct packed {
        logic                  zero_f;
        logic [2:0][OUT_W-1:0] fwd;
        logic                  zero_s;
        logic [2:0][OUT_W-1:0] side;
    } t_basis_sb;

    // The whole pipeline advances unless a finished beat is held.
    logic en;

    logic [2:0][D_W-1:0]   d_vec;
    logic [2:0][IN_W-1:0]  up_in;

    logic                  f_valid;
    logic [2:0][OUT_W-1:0] f_vec;
    logic                  f_zero;
    logic [2:0][IN_W-1:0]  f_up;
    t_fwd_sb               f_sb;

    logic                  c1_valid;
    logic [2:0][C1_W-1:0]  c1_vec;
    t_fwd_sb               c1_sb;

    logic                  s_valid;
    logic [2:0][OUT_W-1:0] s_vec;
    logic                  s_zero;
    t_fwd_sb               s_sb;
    t_basis_sb             s_basis;

    logic                  c2_valid;
    logic [2:0][C2_W-1:0]  c2_vec;
    t_basis_sb             c2_sb;

    logic                  u_valid;
    logic [2:0][OUT_W-1:0] u_vec;
    logic                  u_zero;
    t_basis_sb             u_sb;

    logic                  ok;

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // The difference is taken exactly, one bit wider than the inputs.
    always_comb begin
        d_vec[0] = {i_eye_x[IN_W-1], i_eye_x} - {i_target_x[IN_W-1], i_target_x};
        d_vec[1] = {i_eye_y[IN_W-1], i_eye_y} - {i_target_y[IN_W-1], i_target_y};
        d_vec[2] = {i_eye_z[IN_W-1], i_eye_z} - {i_target_z[IN_W-1], i_target_z};
        up_in[0] = i_up_in_x;
        up_in[1] = i_up_in_y;
        up_in[2] = i_up_in_z;
    end

    lab_norm #(.W(D_W), .SB_W(3 * IN_W)) u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_vec   (d_vec),
        .i_sb    (up_in),
        .o_valid (f_valid),
        .o_vec   (f_vec),
        .o_zero  (f_zero),
        .o_sb    (f_up)
    );

    assign f_sb.zero = f_zero;
    assign f_sb.fwd  = f_vec;

    lab_cross #(.AW(IN_W), .BW(OUT_W), .SB_W($bits(t_fwd_sb))) u_cross_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_a     (f_up),
        .i_b     (f_vec),
        .i_sb    (f_sb),
        .o_valid (c1_valid),
        .o_vec   (c1_vec),
        .o_sb    (c1_sb)
    );

    lab_norm #(.W(C1_W), .SB_W($bits(t_fwd_sb))) u_norm_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (c1_valid),
        .i_vec   (c1_vec),
        .i_sb    (c1_sb),
        .o_valid (s_valid),
        .o_vec   (s_vec),
        .o_zero  (s_zero),
        .o_sb    (s_sb)
    );

    assign s_basis.zero_f = s_sb.zero;
    assign s_basis.fwd    = s_sb.fwd;
    assign s_basis.zero_s = s_zero;
    assign s_basis.side   = s_vec;

    lab_cross #(.AW(OUT_W), .BW(OUT_W), .SB_W($bits(t_basis_sb))) u_cross_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_a     (s_sb.fwd),
        .i_b     (s_vec),
        .i_sb    (s_basis),
        .o_valid (c2_valid),
        .o_vec   (c2_vec),
        .o_sb    (c2_sb)
    );

    lab_norm #(.W(C2_W), .SB_W($bits(t_basis_sb))) u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (c2_valid),
        .i_vec   (c2_vec),
        .i_sb    (c2_sb),
        .o_valid (u_valid),
        .o_vec   (u_vec),
        .o_zero  (u_zero),
        .o_sb    (u_sb)
    );

    // Any null vector along the chain zeroes the whole basis.
    assign ok = !(u_sb.zero_f || u_sb.zero_s || u_zero);

    assign o_valid      = u_valid;
    assign o_degenerate = !ok;
    assign o_side_x     = ok ? u_sb.side[0] : '0;
    assign o_side_y     = ok ? u_sb.side[1] : '0;
    assign o_side_z     = ok ? u_sb.side[2] : '0;
    assign o_up_out_x   = ok ? u_vec[0] : '0;
    assign o_up_out_y   = ok ? u_vec[1] : '0;
    assign o_up_out_z   = ok ? u_vec[2] : '0;
    assign o_fwd_x      = ok ? u_sb.fwd[0] : '0;
    assign o_fwd_y      = ok ? u_sb.fwd[1] : '0;
    assign o_fwd_z      = ok ? u_sb.fwd[2] : '0;

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_side_x == 0 && o_side_y == 0 && o_side_z == 0
            && o_up_out_x == 0 && o_up_out_y == 0 && o_up_out_z == 0
            && o_fwd_x == 0 && o_fwd_y == 0 && o_fwd_z == 0)
        else $error("degenerate beat carries a nonzero axis");
    a_fwd_nonnull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_degenerate |-> o_fwd_x != 0 || o_fwd_y != 0 || o_fwd_z != 0)
        else $error("valid basis with a null forward axis");
    a_side_nonnull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_degenerate |-> o_side_x != 0 || o_side_y != 0 || o_side_z != 0)
        else $error("valid basis with a null side axis");

endmodule

FILE: sim/tb_look_at_basis_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_look_at_basis_unit
// Self-checking testbench for the look-at basis unit.
// ----------------------------------------------------------------------------
// Beats of eye, target and up vectors are sent through the valid/stall input
// channel. Each accepted beat is run through a fixed-point camera-basis model
// in this file, and the expected basis is queued. Every beat leaving the unit
// is compared field by field with the oldest queued basis. Directed vectors
// cover the degenerate cases and the extremes; random vectors follow under
// three idling regimes on both channels.
// ----------------------------------------------------------------------------
module tb_look_at_basis_unit;
    import lab_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 400;
    localparam int RANDOM_BEATS   = 600;   // per idling regime

    // Field indexes into the input and result arrays.
    localparam int EYE_X = 0, TGT_X = 3, UPI_X = 6;
    localparam int SIDE_X = 0, UPO_X = 3, FWD_X = 6;

    typedef struct {
        logic signed [OUT_W-1:0] axis [9];
        logic                    degenerate;
    } t_basis;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    logic signed [IN_W-1:0] vec [9];
    logic in_stall, out_valid, out_degenerate;
    logic signed [OUT_W-1:0] out_axis [9];

    t_basis expected_bases [$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;
    bit failed = 1'b0;

    always #4 clk = ~clk;

    initial begin
        for (int i = 0; i < 9; i++)
            vec[i] = '0;
    end

    look_at_basis_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_eye_x     (vec[0]),
        .i_eye_y     (vec[1]),
        .i_eye_z     (vec[2]),
        .i_target_x  (vec[3]),
        .i_target_y  (vec[4]),
        .i_target_z  (vec[5]),
        .i_up_in_x   (vec[6]),
        .i_up_in_y   (vec[7]),
        .i_up_in_z   (vec[8]),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_side_x    (out_axis[0]),
        .o_side_y    (out_axis[1]),
        .o_side_z    (out_axis[2]),
        .o_up_out_x  (out_axis[3]),
        .o_up_out_y  (out_axis[4]),
        .o_up_out_z  (out_axis[5]),
        .o_fwd_x     (out_axis[6]),
        .o_fwd_y     (out_axis[7]),
        .o_fwd_z     (out_axis[8]),
        .o_degenerate(out_degenerate)
    );

    // Exact integer square root, one result bit per step.
    function automatic longint unsigned isqrt(input longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Scales v to unit length in Q2.14. Returns 0 for a null vector.
    function automatic bit unit_vector(input longint v [3], output longint u [3]);
        longint unsigned mag [3];
        bit neg [3];
        longint unsigned m, s, len, q;
        m = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? -v[i] : v[i];
            if (mag[i] > m)
                m = mag[i];
            u[i] = 0;
        end
        if (m == 0)
            return 1'b0;
        // Bring the largest magnitude into [2^29, 2^30).
        while (m >= (64'd1 << (NORM_BIT + 1))) begin
            m >>= 1;
            for (int i = 0; i < 3; i++)
                mag[i] >>= 1;
        end
        while (m < (64'd1 << NORM_BIT)) begin
            m <<= 1;
            for (int i = 0; i < 3; i++)
                mag[i] <<= 1;
        end
        for (int i = 0; i < 3; i++)
            s += mag[i] * mag[i];
        len = isqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] * UNIT_ONE + len / 2) / len;
            if (q > UNIT_ONE)
                q = UNIT_ONE;
            u[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic void cross3(input longint a [3], input longint b [3],
                                   output longint r [3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic t_basis camera_basis(input logic signed [IN_W-1:0] v [9]);
        longint d [3], upv [3], fwd [3], side [3], upo [3], tmp [3];
        bit ok;
        t_basis b;
        for (int i = 0; i < 3; i++) begin
            d[i] = longint'(v[EYE_X + i]) - longint'(v[TGT_X + i]);
            upv[i] = longint'(v[UPI_X + i]);
        end
        ok = unit_vector(d, fwd);
        cross3(upv, fwd, tmp);
        ok = unit_vector(tmp, side) && ok;
        cross3(fwd, side, tmp);
        ok = unit_vector(tmp, upo) && ok;
        for (int i = 0; i < 3; i++) begin
            b.axis[SIDE_X + i] = ok ? OUT_W'(side[i]) : '0;
            b.axis[UPO_X + i]  = ok ? OUT_W'(upo[i]) : '0;
            b.axis[FWD_X + i]  = ok ? OUT_W'(fwd[i]) : '0;
        end
        b.degenerate = !ok;
        return b;
    endfunction

    // Sends one beat; the expected basis is queued once the beat is taken.
    task automatic send_beat(input logic signed [IN_W-1:0] v [9]);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        vec = v;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        expected_bases.push_back(camera_basis(v));
    endtask

    task automatic send_vectors(input int ex, ey, ez, tx, ty, tz, ux, uy, uz);
        logic signed [IN_W-1:0] v [9];
        v = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
        send_beat(v);
    endtask

    // Degenerate cases, extremes and plain cameras.
    task automatic test_directed();
        int mx, mn;
        mx = 32'h7fffffff;
        mn = 32'h80000000;
        send_vectors(0, 0, 5 << 16, 0, 0, 0, 0, 1 << 16, 0);
        send_vectors(3 << 16, 2 << 16, 1 << 16, 0, 0, 0, 0, 1 << 16, 0);
        send_vectors(1, 2, 3, 1, 2, 3, 0, 1 << 16, 0);          // eye on target
        send_vectors(0, 0, 0, 0, 0, 1 << 16, 0, 0, 0);          // up is null
        send_vectors(0, 0, 0, 0, 0, 1 << 16, 0, 0, -7);         // up along view
        send_vectors(0, 0, 0, 2, 4, 6, 1, 2, 3);                // up along view
        send_vectors(mx, mx, mx, mn, mn, mn, mx, mn, mx);
        send_vectors(mn, mn, mn, mx, mx, mx, mn, mx, mn);
        send_vectors(mx, 0, 0, mn, 0, 0, 0, mx, 0);
        send_vectors(0, mn, 0, 0, mx, 0, mn, 0, 0);
        send_vectors(0, 0, 1, 0, 0, 0, 0, 1, 0);                // one-LSB vectors
        send_vectors(0, 0, 0, 1, 0, 0, 0, 0, -1);
        send_vectors(mx, mx, mx, mx, mx, mx - 1, 1, 0, 0);
        send_vectors(-1, -1, -1, 0, 0, 0, mx, mx, mn);
        send_vectors(1, 1, 0, 0, 0, 0, -1, 1, 0);
        send_vectors(100 << 16, 0, 1, 0, 0, 0, 0, 0, 1 << 16);  // nearly orthogonal
        send_vectors(-5, 7, 11, 13, -17, 19, -23, 29, -31);
        send_vectors(mn, 0, mx, mx, 0, mn, 0, -1, 0);
    endtask

    // Random beats: full-range words, moderate scenes, and up vectors that are
    // a multiple of the view direction, sometimes slightly perturbed.
    task automatic test_random(input int beats);
        logic signed [IN_W-1:0] v [9];
        int kind, k;
        for (int n = 0; n < beats; n++) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                for (int i = 0; i < 9; i++)
                    v[i] = $urandom;
            end else if (kind < 80) begin
                for (int i = 0; i < 9; i++)
                    v[i] = $signed($urandom_range(2 * 1048576)) - 1048576;
            end else begin
                for (int i = 0; i < 6; i++)
                    v[i] = $signed($urandom_range(2000)) - 1000;
                k = $signed($urandom_range(200)) - 100;
                for (int i = 0; i < 3; i++)
                    v[UPI_X + i] = k * (v[EYE_X + i] - v[TGT_X + i])
                                   + (kind < 90 ? $signed($urandom_range(2)) - 1 : 0);
                if ($urandom_range(9) == 0)
                    v[TGT_X + $urandom_range(2)] = v[EYE_X];
            end
            send_beat(v);
        end
    endtask

    // The receiver holds off results at the chosen rate.
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    // Compare each taken result with the oldest expected basis.
    always @(posedge clk) begin
        t_basis want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_bases.size() == 0) begin
                $display("%0t: result beat with no expected basis", $time);
                failed = 1'b1;
            end else begin
                want = expected_bases.pop_front();
                for (int i = 0; i < 9; i++) begin
                    if (out_axis[i] !== want.axis[i]) begin
                        $display("%0t: axis field %0d expected %0d actual %0d",
                                 $time, i, want.axis[i], out_axis[i]);
                        failed = 1'b1;
                    end
                end
                if (out_degenerate !== want.degenerate) begin
                    $display("%0t: degenerate expected %0b actual %0b",
                             $time, want.degenerate, out_degenerate);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 29;
        recv_idle_pct = 47;
        test_directed();
        test_random(RANDOM_BEATS);

        send_idle_pct = 47;
        recv_idle_pct = 29;
        test_random(RANDOM_BEATS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(RANDOM_BEATS);

        @(negedge clk);
        in_valid = 1'b0;
        // The watchdog ends the run if results stop coming.
        while (expected_bases.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (!failed)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
